>>> hw/rtl/tcw_pkg.sv
// Shared constants, types and helpers for the text console writer.
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int CELLS    = COLUMNS * ROWS;
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int CELL_W   = 16;
	localparam int TAB_STOP = 8;
	localparam int TCNT_W   = 4;

	localparam logic [7:0]        ATTR_RESET   = 8'h07;
	localparam logic [7:0]        CH_SPACE     = 8'h20;
	localparam logic [7:0]        CH_NEWLINE   = 8'h0A;
	localparam logic [7:0]        CH_BACKSPACE = 8'h08;
	localparam logic [7:0]        CH_TAB       = 8'h09;
	localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	localparam logic [1:0] REG_ATTR = 2'd0;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WRITE,
		ST_BSPACE,
		ST_SCROLL,
		ST_SCRL_END,
		ST_CLEAR,
		ST_READ,
		ST_RWAIT,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_linear;
		logic        scrolled;
		logic [15:0] cell_word;
	} tcw_result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} tcw_mem_req_t;

	function automatic logic [CELL_W-1:0] blank_cell(input logic [7:0] attr);
		return {attr, CH_SPACE};
	endfunction

endpackage

>>> hw/rtl/tcw_cmd_if.sv
// Input item channel: mode, character byte and cell index.
interface tcw_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  char_code;
	logic [10:0] cell_index;

	modport source (output valid, output mode, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input mode, input char_code, input cell_index,
		output ready);
endinterface

>>> hw/rtl/tcw_rsp_if.sv
// Result channel: cursor position, scroll flag and read-back cell.
interface tcw_rsp_if;
	logic        valid;
	logic        ready;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [10:0] cursor_linear;
	logic        scrolled;
	logic [15:0] cell_word;

	modport source (output valid, output cursor_col, output cursor_row,
		output cursor_linear, output scrolled, output cell_word, input ready);
	modport sink (input valid, input cursor_col, input cursor_row,
		input cursor_linear, input scrolled, input cell_word, output ready);
endinterface

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/tcw_ctrl.sv
// Sequencer and cursor datapath: drives the screen RAM one cell per cycle.
module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	tcw_cmd_if.sink           cmd,
	input  logic [7:0]        attr,
	output tcw_result_t       res,
	output logic              res_valid,
	input  logic              res_take,
	output tcw_mem_req_t      mem_req,
	input  logic [CELL_W-1:0] mem_rdata
);

	tcw_state_t        state_q, state_d;
	logic [ADDR_W-1:0] cnt_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] pos_q;
	logic [TCNT_W-1:0] tcnt_q;
	logic              scrl_q;
	logic              cp_s1;
	logic [ADDR_W-1:0] cpa_s1;
	logic              cpb_s1;
	logic [7:0]        byte_q;
	logic [10:0]       idx_q;
	logic [15:0]       word_q;

	logic              accept;
	logic              col_last;
	logic              row_last;
	logic              cnt_last;
	logic              idx_ok;
	logic [ADDR_W:0]   src_addr;
	logic [ADDR_W-1:0] bottom_pos;

	assign accept     = cmd.valid && cmd.ready;
	assign col_last   = (col_q == COL_W'(COLUMNS - 1));
	assign row_last   = (row_q == ROW_W'(ROWS - 1));
	assign cnt_last   = (cnt_q == ADDR_W'(CELLS - 1));
	assign idx_ok     = ({1'b0, idx_q} < 12'(CELLS));
	assign src_addr   = {1'b0, cnt_q} + (ADDR_W + 1)'(COLUMNS);
	assign bottom_pos = ADDR_W'((ROWS - 1) * COLUMNS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.mode)
						MODE_WRITE: begin
							if (cmd.char_code == CH_NEWLINE) begin
								state_d = row_last ? ST_SCROLL : ST_DONE;
							end else if (cmd.char_code == CH_BACKSPACE) begin
								state_d = ST_BSPACE;
							end else begin
								state_d = ST_WRITE;
							end
						end
						MODE_CLEAR: state_d = ST_CLEAR;
						MODE_READ:  state_d = ST_READ;
						MODE_NOP:   state_d = ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_WRITE: begin
				if (col_last && row_last) state_d = ST_SCROLL;
				else if (tcnt_q == TCNT_W'(1)) state_d = ST_DONE;
			end
			ST_SCROLL: begin
				if (cnt_last) state_d = ST_SCRL_END;
			end
			ST_SCRL_END: state_d = (tcnt_q != '0) ? ST_WRITE : ST_DONE;
			ST_BSPACE:   state_d = ST_DONE;
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_DONE;
			end
			ST_READ:  state_d = ST_RWAIT;
			ST_RWAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM requests
	always_comb begin
		cmd.ready     = (state_q == ST_IDLE);
		res_valid     = (state_q == ST_DONE);
		mem_req.we    = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = blank_cell(attr);
		mem_req.raddr = '0;
		unique case (state_q)
			ST_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q;
				mem_req.wdata = RESET_CELL;
			end
			ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = cnt_q;
			end
			ST_WRITE: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = {attr, byte_q};
			end
			ST_BSPACE: mem_req.we = 1'b1;
			ST_SCROLL: begin
				if (src_addr < (ADDR_W + 1)'(CELLS)) mem_req.raddr = src_addr[ADDR_W-1:0];
			end
			ST_READ: begin
				if (idx_ok) mem_req.raddr = ADDR_W'(idx_q);
			end
			default: ;
		endcase
		// moved row lands in the cycle after its read
		if (cp_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = cpa_s1;
			mem_req.wdata = cpb_s1 ? blank_cell(attr) : mem_rdata;
		end
	end

	assign res.cursor_col    = 7'(col_q);
	assign res.cursor_row    = 5'(row_q);
	assign res.cursor_linear = 11'(pos_q);
	assign res.scrolled      = scrl_q;
	assign res.cell_word     = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pos_q   <= '0;
			tcnt_q  <= '0;
			scrl_q  <= 1'b0;
			cp_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			cp_s1   <= (state_q == ST_SCROLL);
			unique case (state_q)
				ST_INIT, ST_CLEAR, ST_SCROLL: cnt_q <= cnt_q + ADDR_W'(1);
				ST_IDLE: begin
					if (accept) begin
						// a newline on the bottom row scrolls right away
						scrl_q <= (cmd.mode == MODE_WRITE) && (cmd.char_code == CH_NEWLINE)
							&& row_last;
						cnt_q  <= '0;
						if (cmd.mode == MODE_WRITE) begin
							if (cmd.char_code == CH_NEWLINE) begin
								col_q  <= '0;
								tcnt_q <= '0;
								if (row_last) begin
									pos_q  <= bottom_pos;
								end else begin
									row_q <= row_q + ROW_W'(1);
									pos_q <= pos_q + ADDR_W'(COLUMNS) - ADDR_W'(col_q);
								end
							end else if (cmd.char_code == CH_BACKSPACE) begin
								// step back, wrapping to the end of the row above
								if (col_q != '0) begin
									col_q <= col_q - COL_W'(1);
									pos_q <= pos_q - ADDR_W'(1);
								end else if (row_q != '0) begin
									row_q <= row_q - ROW_W'(1);
									col_q <= COL_W'(COLUMNS - 1);
									pos_q <= pos_q - ADDR_W'(1);
								end
							end else if (cmd.char_code == CH_TAB) begin
								tcnt_q <= TCNT_W'(TAB_STOP) - {1'b0, col_q[2:0]};
							end else begin
								tcnt_q <= TCNT_W'(1);
							end
						end else if (cmd.mode == MODE_CLEAR) begin
							col_q <= '0;
							row_q <= '0;
							pos_q <= '0;
						end
					end
				end
				ST_WRITE: begin
					tcnt_q <= tcnt_q - TCNT_W'(1);
					if (!col_last) begin
						col_q <= col_q + COL_W'(1);
						pos_q <= pos_q + ADDR_W'(1);
					end else if (!row_last) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
						pos_q <= pos_q + ADDR_W'(1);
					end else begin
						col_q  <= '0;
						pos_q  <= bottom_pos;
						scrl_q <= 1'b1;
						cnt_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cpa_s1 <= cnt_q;
		cpb_s1 <= (cnt_q >= ADDR_W'(CELLS - COLUMNS));
		if (accept) begin
			idx_q  <= cmd.cell_index;
			word_q <= '0;
			byte_q <= (cmd.char_code == CH_TAB) ? CH_SPACE : cmd.char_code;
		end else if (state_q == ST_RWAIT) begin
			word_q <= idx_ok ? mem_rdata : '0;
		end
	end

endmodule

>>> hw/rtl/text_console_writer.sv
// Text console writer: a plain byte, backspace or tab is written at the cursor, and a
// scroll moves every row up one and blanks the bottom row; a clear blanks every cell.
// The screen RAM has one write port, so cell writes, moves and blanks go one at a time.
// One item is worked on at a time; the result register lets the next item in meanwhile.
// After reset the block sweeps all COLUMNS*ROWS (2000) cells to blank 0x0720 before
// taking an item; the attribute register resets to 0x07.
module text_console_writer
	import tcw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tcw_cmd_if.sink     cmd,
	tcw_rsp_if.source   rsp
);

	logic [7:0]   attr_q;
	logic         out_valid_q;
	tcw_result_t  out_q;
	tcw_result_t  res;
	logic         res_valid;
	logic         res_take;
	tcw_mem_req_t mem_req;
	logic [15:0]  mem_rdata;

	assign pready = 1'b1;
	assign prdata = {24'd0, attr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_ATTR)) begin
			attr_q <= pwdata[7:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.attr      (attr_q),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// hold the finished word until the sink takes it
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.cursor_col    = out_q.cursor_col;
	assign rsp.cursor_row    = out_q.cursor_row;
	assign rsp.cursor_linear = out_q.cursor_linear;
	assign rsp.scrolled      = out_q.scrolled;
	assign rsp.cell_word     = out_q.cell_word;

endmodule
